>>> hw/rtl/gds_pkg.sv
// Shared types and constants for the Gregorian day span block.
package gds_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SPAN_W   = 22;
    localparam int DAYNUM_W = 23;
    localparam int YBIAS_W  = YEAR_W + 1;

    localparam logic [YBIAS_W-1:0] YEAR_BIAS = YBIAS_W'(400);
    localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for x below 7989
    localparam int DIV25_SHIFT = 22;
    localparam int DIV25_MUL_W = 18;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = DIV25_MUL_W'(167773);

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    // days before each month, counted from March 1; unused codes are zero
    localparam logic [8:0] MONTH_OFS [16] = '{
        9'd0,   9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd0,   9'd0,   9'd0
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

endpackage

>>> hw/rtl/gds_day_number.sv
// Converts one calendar date to a linear day number.
module gds_day_number (
    input  gds_pkg::date_t                  date,
    output logic [gds_pkg::DAYNUM_W-1:0]    day_num
);
    import gds_pkg::*;

    localparam int Q4_W   = YBIAS_W - 2;
    localparam int PROD_W = Q4_W + DIV25_MUL_W;
    localparam int Q100_W = PROD_W - DIV25_SHIFT;

    logic [MONTH_W-1:0] month_c;
    logic               early;
    logic [YBIAS_W-1:0] y;
    logic [Q4_W-1:0]    q4;
    logic [PROD_W-1:0]  prod;
    logic [Q100_W-1:0]  q100;
    logic [DAYNUM_W-1:0] y365;

    always_comb
    begin
        if (date.month < MONTH_MIN)
        begin
            month_c = MONTH_MIN;
        end
        else if (date.month > MONTH_MAX)
        begin
            month_c = MONTH_MAX;
        end
        else
        begin
            month_c = date.month;
        end
    end

    // Jan and Feb count as months of the previous year
    assign early = (month_c <= MONTH_FEB);
    assign y     = YBIAS_W'(date.year) + YEAR_BIAS - YBIAS_W'(early);
    assign q4    = y[YBIAS_W-1:2];
    assign prod  = PROD_W'(q4) * PROD_W'(DIV25_MUL);
    assign q100  = prod[PROD_W-1:DIV25_SHIFT];
    assign y365  = DAYNUM_W'(y) * DAYNUM_W'(365);

    assign day_num = y365 + DAYNUM_W'(q4) - DAYNUM_W'(q100)
                   + DAYNUM_W'(q100[Q100_W-1:2])
                   + DAYNUM_W'(MONTH_OFS[month_c]) + DAYNUM_W'(date.day);

endmodule

>>> hw/rtl/gregorian_day_span.sv
// Top level: days between two Gregorian dates, three-stage pipeline.
//
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_ready   | start/end year, month, day; count_end_day
//  output  | out_valid / out_ready | span_valid, span_days
//
//  One word per cycle unless a low out_ready stalls the output stage.
//  Stages: input register, day numbers + order test, span subtract/saturate.
//  Each stage advances when empty or when the stage after it advances.
//  Reset clears the stage valid bits only; the pipeline starts empty.
module gregorian_day_span (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gds_pkg::YEAR_W-1:0]      start_year,
    input  logic [gds_pkg::MONTH_W-1:0]     start_month,
    input  logic [gds_pkg::DAY_W-1:0]       start_day,
    input  logic [gds_pkg::YEAR_W-1:0]      end_year,
    input  logic [gds_pkg::MONTH_W-1:0]     end_month,
    input  logic [gds_pkg::DAY_W-1:0]       end_day,
    input  logic                            count_end_day,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            span_valid,
    output logic [gds_pkg::SPAN_W-1:0]      span_days
);
    import gds_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_adv, s2_adv, out_adv;

    date_t s1_start_reg, s1_end_reg;
    logic  s1_inc_reg;

    logic [DAYNUM_W-1:0] dn_start, dn_end;
    logic                start_first;

    logic [DAYNUM_W-1:0] s2_a_reg, s2_b_reg;
    logic                s2_before_reg, s2_inc_reg;

    logic [DAYNUM_W:0]   span_sum;
    logic [SPAN_W-1:0]   span_sat;

    logic                span_valid_reg;
    logic [SPAN_W-1:0]   span_days_reg;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    assign s1_valid_next  = s1_adv  ? in_valid     : s1_valid_reg;
    assign s2_valid_next  = s2_adv  ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_adv ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    gds_day_number u_dn_start (
        .date    (s1_start_reg),
        .day_num (dn_start)
    );

    gds_day_number u_dn_end (
        .date    (s1_end_reg),
        .day_num (dn_end)
    );

    // order test on raw fields: year, then month, then day
    assign start_first = s1_start_reg < s1_end_reg;

    always_comb
    begin
        if (s2_b_reg > s2_a_reg)
        begin
            span_sum = (DAYNUM_W+1)'(s2_b_reg - s2_a_reg) + (DAYNUM_W+1)'(s2_inc_reg);
        end
        else
        begin
            span_sum = (DAYNUM_W+1)'(s2_inc_reg);
        end
        if (span_sum > (DAYNUM_W+1)'(SPAN_MAX))
        begin
            span_sat = SPAN_MAX;
        end
        else
        begin
            span_sat = span_sum[SPAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_start_reg <= '{year: start_year, month: start_month, day: start_day};
            s1_end_reg   <= '{year: end_year, month: end_month, day: end_day};
            s1_inc_reg   <= count_end_day;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_a_reg      <= dn_start;
            s2_b_reg      <= dn_end;
            s2_before_reg <= start_first;
            s2_inc_reg    <= s1_inc_reg;
        end
        if (out_adv && s2_valid_reg)
        begin
            span_valid_reg <= s2_before_reg;
            span_days_reg  <= s2_before_reg ? span_sat : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_valid = span_valid_reg;
    assign span_days  = span_days_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> span_days == '0)
        else $error("invalid span with nonzero day count");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("word accepted into a full pipeline");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted word lost at input stage");

    a_s2_move: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && out_adv |=> out_valid_reg)
        else $error("word lost between middle and output stage");

endmodule
